@@ design/vdi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int ATTR_W     = 32;   // one raw attribute word
  localparam int KEY_W      = 64;   // one stored key word (two attributes)
  localparam int KEY_WORDS  = 4;    // key words per vertex
  localparam int WORD_SEL_W = 2;    // selects one key word of a vertex
  localparam int INDEX_W    = 10;   // width of the returned index

  typedef logic [KEY_W-1:0] key_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_WRITE,
    ST_FINISH
  } vdi_state_t;

  // Request from the sequencer to the key store
  typedef struct packed {
    logic rd;
    logic wr;
  } key_cmd_t;

endpackage

@@ design/vdi_key_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_key_store
// Single-port key memory with registered read and the shared key comparator.
// ----------------------------------------------------------------------------
module vdi_key_store
  import vdi_pkg::*;
#(
  parameter int ENTRIES = 1024
) (
  input  logic                                   clk,
  input  key_cmd_t                               cmd,
  input  logic [$clog2(ENTRIES)+WORD_SEL_W-1:0]  addr,
  input  key_word_t                              word_in,
  output logic                                   match
);

  key_word_t mem [ENTRIES*KEY_WORDS];
  key_word_t rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= word_in;
    end
    if (cmd.rd) begin
      rd_data <= mem[addr];
    end
  end

  // compare the word read last cycle against the same word of the search key
  assign match = (rd_data == word_in);

endmodule

@@ design/vertex_dedup_indexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Vertex deduplication for an index buffer: returns the index of each vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one vertex per transfer, eight raw
//   32-bit attribute words and a new_mesh flag that empties the table first.
//   Output channel (out_valid / out_stall): one result per vertex, giving
//   vertex_index, is_new (vertex stored by this transfer) and overflow (new
//   vertex found the table full; index 0, nothing stored).
//   Vertices are kept in order of arrival in a single-port key memory; a fill
//   count marks the live entries, so new_mesh clears the table at once.
//   Search: the search walks the stored vertices one 64-bit key word at a
//   time through one shared comparator; each compared word is first read
//   from memory, then compared, and a mismatch moves on to the next vertex.
//   Each item steps through accept, the word compares, a hit or (once the
//   stored vertices run out) a miss, the four key-word writes on an insert
//   and the finishing state, where it waits out any output stall.
//   The block handles one vertex at a time: in_stall is high from the
//   transfer until the result is placed in the output register. A new vertex
//   may be taken while that result still waits to be taken.
//   When the receiver stalls, the result holds in the output register; a
//   finished search waits in its finishing state until the register frees.
//   Reset empties the table and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer
  import vdi_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               new_mesh,
  input  logic [ATTR_W-1:0]  pos_x,
  input  logic [ATTR_W-1:0]  pos_y,
  input  logic [ATTR_W-1:0]  pos_z,
  input  logic [ATTR_W-1:0]  norm_x,
  input  logic [ATTR_W-1:0]  norm_y,
  input  logic [ATTR_W-1:0]  norm_z,
  input  logic [ATTR_W-1:0]  tex_u,
  input  logic [ATTR_W-1:0]  tex_v,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] vertex_index,
  output logic               is_new,
  output logic               overflow
);

  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W  = SLOT_W + WORD_SEL_W;
  localparam logic [COUNT_W-1:0]    FULL_COUNT = COUNT_W'(TABLE_ENTRIES);
  localparam logic [WORD_SEL_W-1:0] LAST_WORD  = WORD_SEL_W'(KEY_WORDS - 1);

  // Sequencer and table state
  vdi_state_t              state, state_next;
  logic [COUNT_W-1:0]      count, count_next;     // stored vertices
  logic [COUNT_W-1:0]      slot, slot_next;       // vertex under comparison
  logic [WORD_SEL_W-1:0]   word, word_next;       // key word under comparison
  key_word_t               key [KEY_WORDS];       // search key of this vertex

  // Pending result and output register
  logic [COUNT_W-1:0]      res_index, res_index_next;
  logic                    res_new, res_new_next;
  logic                    res_ovf, res_ovf_next;
  logic                    out_valid_next;
  logic                    out_load;

  // Key store interface
  key_cmd_t                cmd;
  logic [ADDR_W-1:0]       addr;
  key_word_t               word_in;
  logic                    match;

  logic                    in_take;
  logic                    out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign word_in  = key[word];

  // ---------------------------------------------------------------------------
  // Next state and key store requests
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    count_next     = count;
    slot_next      = slot;
    word_next      = word;
    res_index_next = res_index;
    res_new_next   = res_new;
    res_ovf_next   = res_ovf;
    cmd            = '{rd: 1'b0, wr: 1'b0};
    addr           = {slot[SLOT_W-1:0], word};
    out_load       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          // new mesh: drop every stored vertex before the search
          if (new_mesh) begin
            count_next = '0;
          end
          slot_next  = '0;
          word_next  = '0;
          state_next = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (slot < count) begin
          // read the next key word of a live entry
          cmd.rd     = 1'b1;
          state_next = ST_CMP;
        end else if (count < FULL_COUNT) begin
          // miss with room left: store under the next free index
          word_next  = '0;
          state_next = ST_WRITE;
        end else begin
          // miss with the table full
          res_index_next = '0;
          res_new_next   = 1'b0;
          res_ovf_next   = 1'b1;
          state_next     = ST_FINISH;
        end
      end

      ST_CMP: begin
        if (match && (word == LAST_WORD)) begin
          res_index_next = slot;
          res_new_next   = 1'b0;
          res_ovf_next   = 1'b0;
          state_next     = ST_FINISH;
        end else if (match) begin
          word_next  = word + 1'b1;
          state_next = ST_SCAN;
        end else begin
          // first differing word: advance to the next entry
          slot_next  = slot + 1'b1;
          word_next  = '0;
          state_next = ST_SCAN;
        end
      end

      ST_WRITE: begin
        cmd.wr    = 1'b1;
        addr      = {count[SLOT_W-1:0], word};
        word_next = word + 1'b1;
        if (word == LAST_WORD) begin
          res_index_next = count;
          res_new_next   = 1'b1;
          res_ovf_next   = 1'b0;
          count_next     = count + 1'b1;
          state_next     = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    slot      <= slot_next;
    word      <= word_next;
    res_index <= res_index_next;
    res_new   <= res_new_next;
    res_ovf   <= res_ovf_next;
    if (in_take) begin
      // pack attribute pairs low word first, as the table stores them
      key[0] <= {pos_y,  pos_x};
      key[1] <= {norm_x, pos_z};
      key[2] <= {norm_z, norm_y};
      key[3] <= {tex_v,  tex_u};
    end
    if (out_load) begin
      vertex_index <= INDEX_W'(res_index);
      is_new       <= res_new;
      overflow     <= res_ovf;
    end
  end

  // ---------------------------------------------------------------------------
  // Key memory and shared comparator
  // ---------------------------------------------------------------------------
  vdi_key_store #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_key_store (
    .clk     (clk),
    .cmd     (cmd),
    .addr    (addr),
    .word_in (word_in),
    .match   (match)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count beyond table size");

  a_cmp_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (slot < count))
    else $error("compare on an entry that is not live");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && word == LAST_WORD) |=> (count == $past(count) + 1'b1))
    else $error("insert did not advance the fill count");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && overflow))
    else $error("result flagged both new and overflow");

  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (vertex_index == '0))
    else $error("overflow result with a non-zero index");

endmodule
